/* sv/wmd_pkg.sv */
// Shared constants, register codes and the vote function of the 3x3 majority denoiser.
`default_nettype none
package wmd_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_THRESHOLD = 2'd2;

  localparam int IW_BITS  = 11;
  localparam int IH_BITS  = 12;
  localparam int PIX_BITS = 8;

  localparam logic [IW_BITS-1:0]  RST_IMAGE_WIDTH     = 11'd640;
  localparam logic [IH_BITS-1:0]  RST_IMAGE_HEIGHT    = 12'd480;
  localparam logic [PIX_BITS-1:0] RST_WHITE_THRESHOLD = 8'd128;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4095;

  // result beats buffered between the vote stage and the output port
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  // window shift keeps the two left columns, drops the oldest column
  localparam logic [8:0] WIN_KEEP = 9'h0DB;

  localparam logic [PIX_BITS-1:0] PIX_WHITE = 8'hFF;
  localparam logic [PIX_BITS-1:0] PIX_BLACK = 8'h00;
  localparam logic [3:0]          VOTE_MIN  = 4'd8;

  // corners weigh 1, edges 2, center 3; white wins at 8 of 15
  function automatic logic vote_white(input logic [8:0] win);
    logic [3:0] sum;
    sum = 4'({3'b000, win[0]}) + 4'({3'b000, win[2]}) + 4'({3'b000, win[6]})
        + 4'({3'b000, win[8]})
        + 4'({2'b00, win[1], 1'b0}) + 4'({2'b00, win[3], 1'b0})
        + 4'({2'b00, win[5], 1'b0}) + 4'({2'b00, win[7], 1'b0})
        + 4'({2'b00, win[4], win[4]});
    return (sum >= VOTE_MIN);
  endfunction

endpackage
`default_nettype wire

/* sv/weighted_majority_denoise_3x3_top.sv */
// Top level of the weighted 3x3 majority denoiser: counters, vote stage and ports.
//
// Use:
//   in_*  : one 8-bit pixel per beat, raster order; the frame wraps after
//           width x height pixels. Up to one beat per cycle.
//   out_* : result beats carrying row, column, value and a last flag that
//           marks the final beat caused by one input pixel. A border pixel
//           yields its own value; once row and column reach 2 the filtered
//           0/255 result for (row-1, col-1) follows. Zero to two beats per pixel.
//   cfg_* : register writes (width, height, threshold), always ready; write
//           only while the block is idle. Index 3 is ignored.
// Path: an accepted pixel is registered into the vote stage with its line
//   store read, then voted into the result queue, before its first beat is taken.
// Throughput: one pixel per cycle while the vote stage is not held, set by
//   the single line store port pair; output is one beat per cycle, so rows
//   and columns with two beats per pixel slow the input to the output rate.
// Reset: counters, window and queue clear; the line stores are not cleared
//   and hold stale flags until the first rows of a frame overwrite them.
// Stall: the four-beat result queue absorbs output stalls; when it cannot
//   take a pixel's beats the vote stage holds and in_ready drops.
`default_nettype none
module weighted_majority_denoise_3x3_top #(
  parameter int MAX_WIDTH  = wmd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = wmd_pkg::DEF_MAX_HEIGHT,
  localparam int CB = $clog2(MAX_WIDTH),
  localparam int RB = $clog2(MAX_HEIGHT)
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [wmd_pkg::PIX_BITS-1:0]    in_pixel_value,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [RB-1:0]                        out_row,
  output logic [CB-1:0]                        out_col,
  output logic [wmd_pkg::PIX_BITS-1:0]         out_value,
  output logic                                 out_last_of_run,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [wmd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [wmd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int PB     = wmd_pkg::PIX_BITS;
  localparam int WCL    = $clog2(MAX_WIDTH + 1);
  localparam int HCL    = $clog2(MAX_HEIGHT + 1);
  localparam int WB     = (wmd_pkg::IW_BITS > WCL) ? wmd_pkg::IW_BITS : WCL;
  localparam int HB     = (wmd_pkg::IH_BITS > HCL) ? wmd_pkg::IH_BITS : HCL;
  localparam int BEAT_W = RB + CB + PB + 1;
  localparam int FCW    = wmd_pkg::FIFO_CNT_W;

  // vote stage control, registered at pixel accept
  typedef struct packed {
    logic border;
    logic filt;
    logic cur;
  } s1_ctl_t;

  // ---------------------------------------------------------------- config
  logic [wmd_pkg::IW_BITS-1:0] image_width_r;
  logic [wmd_pkg::IH_BITS-1:0] image_height_r;
  logic [PB-1:0]               white_threshold_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r     <= wmd_pkg::RST_IMAGE_WIDTH;
      image_height_r    <= wmd_pkg::RST_IMAGE_HEIGHT;
      white_threshold_r <= wmd_pkg::RST_WHITE_THRESHOLD;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wmd_pkg::REG_IMAGE_WIDTH: begin
          image_width_r <= cfg_data[wmd_pkg::IW_BITS-1:0];
        end
        wmd_pkg::REG_IMAGE_HEIGHT: begin
          image_height_r <= cfg_data[wmd_pkg::IH_BITS-1:0];
        end
        wmd_pkg::REG_WHITE_THRESHOLD: begin
          white_threshold_r <= cfg_data[PB-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // frame size clamped to 1..MAX
  logic [WB-1:0] w_eff, iw_ext;
  logic [HB-1:0] h_eff, ih_ext;

  always_comb begin
    iw_ext = WB'(image_width_r);
    ih_ext = HB'(image_height_r);
    if (iw_ext == '0)                 w_eff = WB'(1);
    else if (iw_ext > WB'(MAX_WIDTH)) w_eff = WB'(MAX_WIDTH);
    else                              w_eff = iw_ext;
    if (ih_ext == '0)                  h_eff = HB'(1);
    else if (ih_ext > HB'(MAX_HEIGHT)) h_eff = HB'(MAX_HEIGHT);
    else                               h_eff = ih_ext;
  end

  // -------------------------------------------------------------- counters
  logic [CB-1:0] col_r;
  logic [RB-1:0] row_r;
  logic [WB-1:0] c0, c1, col_nxt;
  logic [HB-1:0] r0a, r0, r1, row_nxt;
  logic          in_acc;
  logic          border_c, filt_c;

  assign in_acc = in_valid && in_ready;

  always_comb begin
    // a size change may leave the counters past the new bounds
    if (WB'(col_r) >= w_eff) begin
      c0  = '0;
      r0a = HB'(row_r) + HB'(1);
    end else begin
      c0  = WB'(col_r);
      r0a = HB'(row_r);
    end
    r0 = (r0a >= h_eff) ? '0 : r0a;
    c1 = c0 + WB'(1);
    r1 = r0 + HB'(1);
    if (c1 >= w_eff) begin
      col_nxt = '0;
      row_nxt = (r1 >= h_eff) ? '0 : r1;
    end else begin
      col_nxt = c1;
      row_nxt = r0;
    end
    border_c = (r0 == '0) || (c0 == '0) || (r1 >= h_eff) || (c1 >= w_eff);
    filt_c   = (r0 >= HB'(2)) && (c0 >= WB'(2));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= CB'(col_nxt);
      row_r <= RB'(row_nxt);
    end
  end

  // ------------------------------------------------------------ vote stage
  logic          s1_valid_r;
  s1_ctl_t       s1_ctl_r;
  logic [PB-1:0] s1_pix_r;
  logic [CB-1:0] s1_col_r;
  logic [RB-1:0] s1_row_r;
  logic [8:0]    win_r, win_nxt;
  logic [1:0]    line_rd;
  logic          s1_fire;
  logic [FCW-1:0] fifo_level;
  logic [FCW-1:0] n_beats;

  assign n_beats  = FCW'({1'b0, s1_ctl_r.border}) + FCW'({1'b0, s1_ctl_r.filt});
  assign s1_fire  = s1_valid_r
                 && ((fifo_level + n_beats) <= FCW'(wmd_pkg::FIFO_DEPTH));
  assign in_ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r        <= in_pixel_value;
      s1_col_r        <= CB'(c0);
      s1_row_r        <= RB'(r0);
      s1_ctl_r.border <= border_c;
      s1_ctl_r.filt   <= filt_c;
      s1_ctl_r.cur    <= (in_pixel_value >= white_threshold_r);
    end
  end

  // line_rd: bit 1 upper flag, bit 0 middle flag of this column
  assign win_nxt = ((win_r >> 1) & wmd_pkg::WIN_KEEP)
                 | {s1_ctl_r.cur, 2'b00, line_rd[0], 2'b00, line_rd[1], 2'b00};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s1_fire) begin
      win_r <= win_nxt;
    end
  end

  wmd_line_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (CB'(c0)),
    .rd_data (line_rd),
    .wr_en   (s1_fire),
    .wr_addr (s1_col_r),
    .wr_data ({line_rd[0], s1_ctl_r.cur})
  );

  // --------------------------------------------------------- result queue
  logic [BEAT_W-1:0] beat_filt, beat_pass, beat0, q_data;
  logic [PB-1:0]     vote_val;

  assign vote_val  = wmd_pkg::vote_white(win_nxt) ? wmd_pkg::PIX_WHITE
                                                  : wmd_pkg::PIX_BLACK;
  assign beat_filt = {s1_row_r - RB'(1), s1_col_r - CB'(1), vote_val, 1'b1};
  assign beat_pass = {s1_row_r, s1_col_r, s1_pix_r, !s1_ctl_r.filt};
  assign beat0     = s1_ctl_r.border ? beat_pass : beat_filt;

  wmd_out_fifo #(
    .DATA_W (BEAT_W)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push0     (s1_fire && (s1_ctl_r.border || s1_ctl_r.filt)),
    .push1     (s1_fire && s1_ctl_r.border && s1_ctl_r.filt),
    .data0     (beat0),
    .data1     (beat_filt),
    .level     (fifo_level),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (q_data)
  );

  assign out_row         = q_data[BEAT_W-1 -: RB];
  assign out_col         = q_data[CB+PB : PB+1];
  assign out_value       = q_data[PB:1];
  assign out_last_of_run = q_data[0];

`ifndef SYNTH
  // queue never overflows its four beats
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_level <= FCW'(wmd_pkg::FIFO_DEPTH))
    else $error("result queue over depth");

  // a held vote stage keeps its pixel and column
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_fire) |=> (s1_valid_r && $stable(s1_col_r)
                                  && $stable(s1_row_r)))
    else $error("vote stage lost its pixel while held");

  // the window only moves when a pixel leaves the vote stage
  a_win_moves: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_fire |=> $stable(win_r))
    else $error("window changed without a pixel");

  // a filtered result needs a full window to its upper left
  a_filt_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_ctl_r.filt) |-> ((s1_col_r >= CB'(2)) && (s1_row_r >= RB'(2))))
    else $error("filtered result too close to frame origin");

  // counters stay inside the configured maximum
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(col_r) < MAX_WIDTH) && (32'(row_r) < MAX_HEIGHT))
    else $error("position counter out of range");
`endif

endmodule
`default_nettype wire

/* sv/wmd_line_mem.sv */
// Line store memory: upper and middle white flags per column, registered read with write forwarding.
`default_nettype none
module wmd_line_mem #(
  parameter int DEPTH = wmd_pkg::DEF_MAX_WIDTH,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic [1:0]         rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [1:0]    wr_data
);

  logic [1:0] mem [DEPTH];
  logic [1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // same-column write in the read cycle wins (width-one frames)
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

/* sv/wmd_out_fifo.sv */
// Four-beat result queue taking up to two beats per cycle and giving one per cycle while out_ready is high.
`default_nettype none
module wmd_out_fifo #(
  parameter int DATA_W = 31
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              push0,
  input  wire logic                              push1,
  input  wire logic [DATA_W-1:0]                 data0,
  input  wire logic [DATA_W-1:0]                 data1,
  output logic [wmd_pkg::FIFO_CNT_W-1:0]         level,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [DATA_W-1:0]                      out_data
);

  localparam int PW = wmd_pkg::FIFO_PTR_W;
  localparam int CW = wmd_pkg::FIFO_CNT_W;

  logic [DATA_W-1:0] buf_r [wmd_pkg::FIFO_DEPTH];
  logic [PW-1:0]     wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     npush;
  logic              pop;

  assign pop   = out_valid && out_ready;
  assign npush = CW'({1'b0, push0}) + CW'({1'b0, push1});

  always_comb begin
    wp_nxt  = wp_r + PW'(npush);
    rp_nxt  = rp_r + PW'({1'b0, pop});
    cnt_nxt = cnt_r + npush - CW'({1'b0, pop});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      buf_r[wp_r] <= data0;
    end
    if (push1) begin
      buf_r[wp_r + PW'(1)] <= data1;
    end
  end

  assign level     = cnt_r;
  assign out_valid = (cnt_r != '0);
  assign out_data  = buf_r[rp_r];

endmodule
`default_nettype wire
